@@ rtl/core/fchp_pkg.sv @@
package fchp_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_TABLE
    } phase_t;

    // result kind codes
    typedef enum logic [2:0] {
        K_DESC,
        K_ENTRY,
        K_END,
        K_BAD_FILM,
        K_BAD_VERSION,
        K_BAD_FDSC,
        K_BAD_STAB,
        K_UNKNOWN_CODEC
    } kind_t;

    // codec kind codes
    localparam logic [1:0] CODEC_NONE = 2'd0;
    localparam logic [1:0] CODEC_CVID = 2'd1;
    localparam logic [1:0] CODEC_RAW  = 2'd2;

    // big-endian chunk tags and special words
    localparam logic [31:0] TAG_FILM    = 32'h4649_4C4D;
    localparam logic [31:0] TAG_FDSC    = 32'h4644_5343;
    localparam logic [31:0] TAG_STAB    = 32'h5354_4142;
    localparam logic [31:0] TAG_CVID    = 32'h6376_6964;
    localparam logic [31:0] TAG_RAW     = 32'h7261_7720;
    localparam logic [31:0] BAD_VERSION = 32'h0002_0000;
    localparam logic [31:0] AUDIO_MARK  = 32'hFFFF_FFFF;

    // header byte positions
    localparam logic [6:0] HP_FILM     = 7'd3;
    localparam logic [6:0] HP_HDR_LEN  = 7'd7;
    localparam logic [6:0] HP_VERSION  = 7'd11;
    localparam logic [6:0] HP_FDSC     = 7'd19;
    localparam logic [6:0] HP_CODEC    = 7'd27;
    localparam logic [6:0] HP_HEIGHT   = 7'd31;
    localparam logic [6:0] HP_WIDTH    = 7'd35;
    localparam logic [6:0] HP_DEPTH    = 7'd36;
    localparam logic [6:0] HP_CHANNELS = 7'd37;
    localparam logic [6:0] HP_SAMPBITS = 7'd38;
    localparam logic [6:0] HP_RATE     = 7'd41;
    localparam logic [6:0] HP_STAB     = 7'd51;
    localparam logic [6:0] HP_TIMING   = 7'd59;
    localparam logic [6:0] HP_COUNT    = 7'd63;

    // sample table entry byte positions
    localparam logic [3:0] TP_OFFSET = 4'd3;
    localparam logic [3:0] TP_LENGTH = 4'd7;
    localparam logic [3:0] TP_INFO0  = 4'd11;
    localparam logic [3:0] TP_INFO1  = 4'd15;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  codec_kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [7:0]  bits_per_pixel;
        logic [7:0]  audio_channels;
        logic [7:0]  audio_sample_bits;
        logic [15:0] audio_frequency;
        logic        last_of_run;
    } result_t;

    // results written by one byte, up to two
    typedef struct packed {
        logic [1:0] n;
        result_t    item0;
        result_t    item1;
    } push_t;

    typedef struct packed {
        logic valid;
        logic room2;
    } fifo_status_t;

    function automatic logic [1:0] codec_code(input logic [31:0] tag);
        logic [1:0] code;
        code = CODEC_NONE;
        if (tag == TAG_CVID) begin
            code = CODEC_CVID;
        end else if (tag == TAG_RAW) begin
            code = CODEC_RAW;
        end
        return code;
    endfunction

endpackage

@@ rtl/core/fchp_result_fifo.sv @@
module fchp_result_fifo
    import fchp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  push_t        push,
    input  logic         pop,
    output result_t      head,
    output fifo_status_t status
);

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_inc  = FIFO_PTR_W'(wr_ptr_reg + 1'b1);
        wr_ptr_next = FIFO_PTR_W'(wr_ptr_reg + push.n);
        rd_ptr_next = FIFO_PTR_W'(rd_ptr_reg + pop);
        cnt_next    = FIFO_CNT_W'(cnt_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.item1;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.valid = (cnt_reg != '0);
    assign status.room2 = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> status.room2)
        else $error("results written without room for two");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> status.valid)
        else $error("read from empty result queue");

endmodule

@@ rtl/core/film_container_header_parser_core.sv @@
// a result item is queued as its byte is accepted and shows on m_ after older items
// one byte per cycle while s_tready is high; a byte causes zero, one or two result items
// s_tready drops only while the four-entry result queue holds more than two items
// reset: aresetn synchronous, active low; parser goes idle and the result queue empties
// after reset, bytes are ignored until one arrives with the start flag in s_tuser
module film_container_header_parser_core
    import fchp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic [0:0]   s_tuser,   // [0] start_of_stream
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // word_a, word_b, word_c, word_d, bits_per_pixel,
                                    // audio_channels, audio_sample_bits, audio_frequency
    output logic [4:0]   m_tuser,   // [2:0] kind, [4:3] codec_kind
    output logic         m_tlast    // last_of_run
);

    // parser state
    phase_t       phase_reg, phase_next;
    logic [6:0]   pos_reg, pos_next;
    logic [31:0]  ws_reg, ws_next;
    logic [31:0]  vf_reg, vf_next;
    logic [31:0]  entries_reg, entries_next;

    // description fields, written before any read within a run, no reset
    logic [31:0]  hdr_len_reg, hdr_len_next;
    logic [31:0]  codec_reg, codec_next;
    logic [31:0]  width_reg, width_next;
    logic [31:0]  height_reg, height_next;
    logic [23:0]  fmt_reg, fmt_next;
    logic [15:0]  rate_reg, rate_next;
    logic [31:0]  timing_reg, timing_next;
    logic [31:0]  ew0_reg, ew0_next;
    logic [31:0]  ew1_reg, ew1_next;
    logic [31:0]  ew2_reg, ew2_next;

    // per-byte working values
    logic         accept;
    logic         start;
    phase_t       phase_cur;
    logic [6:0]   pos_cur;
    logic [3:0]   tpos;
    logic [31:0]  ws_cur;
    logic [31:0]  vf_cur;
    logic [31:0]  word;
    logic [31:0]  vf_end;
    logic [31:0]  entries_dec;
    logic         tag_ok;
    result_t      end_item;
    result_t      fail_item;
    push_t        push;

    result_t      head;
    fifo_status_t status;
    logic         pop;

    assign accept = s_tvalid && s_tready;
    assign start  = s_tuser[0];

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        ws_next      = ws_reg;
        vf_next      = vf_reg;
        entries_next = entries_reg;
        hdr_len_next = hdr_len_reg;
        codec_next   = codec_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        fmt_next     = fmt_reg;
        rate_next    = rate_reg;
        timing_next  = timing_reg;
        ew0_next     = ew0_reg;
        ew1_next     = ew1_reg;
        ew2_next     = ew2_reg;
        push         = '0;
        fail_item    = '0;
        end_item     = '0;

        // start flag restarts the run as if the state were cleared
        phase_cur   = start ? PH_HEADER : phase_reg;
        pos_cur     = start ? 7'd0 : pos_reg;
        ws_cur      = start ? 32'd0 : ws_reg;
        vf_cur      = start ? 32'd0 : vf_reg;
        tpos        = pos_cur[3:0];
        word        = {ws_cur[23:0], s_tdata};
        entries_dec = entries_reg - 32'd1;
        tag_ok      = (codec_reg == TAG_CVID) || (codec_reg == TAG_RAW) || (codec_reg == '0);

        // video count as of the end of the table; the last entry may add one
        vf_end = vf_cur;
        if (phase_cur == PH_TABLE && ew2_reg != AUDIO_MARK) begin
            vf_end = vf_cur + 32'd1;
        end

        // end marker or unknown codec error, always the final item of its byte
        end_item.last_of_run = 1'b1;
        if (tag_ok) begin
            end_item.kind       = K_END;
            end_item.codec_kind = codec_code(codec_reg);
            end_item.word_a     = vf_end;
        end else begin
            end_item.kind = K_UNKNOWN_CODEC;
        end
        fail_item.last_of_run = 1'b1;

        if (accept && phase_cur != PH_IDLE) begin
            phase_next = phase_cur;
            ws_next    = word;
            vf_next    = vf_cur;
            unique case (phase_cur)
                PH_HEADER: begin
                    pos_next = pos_cur + 7'd1;
                    unique case (pos_cur)
                        HP_FILM: begin
                            if (word != TAG_FILM) begin
                                fail_item.kind = K_BAD_FILM;
                                push.n         = 2'd1;
                                push.item0     = fail_item;
                                phase_next     = PH_IDLE;
                            end
                        end
                        HP_HDR_LEN: hdr_len_next = word;
                        HP_VERSION: begin
                            if (word == '0 || word == BAD_VERSION) begin
                                fail_item.kind = K_BAD_VERSION;
                                push.n         = 2'd1;
                                push.item0     = fail_item;
                                phase_next     = PH_IDLE;
                            end
                        end
                        HP_FDSC: begin
                            if (word != TAG_FDSC) begin
                                fail_item.kind = K_BAD_FDSC;
                                push.n         = 2'd1;
                                push.item0     = fail_item;
                                phase_next     = PH_IDLE;
                            end
                        end
                        HP_CODEC:  codec_next  = word;
                        HP_HEIGHT: height_next = word;
                        HP_WIDTH:  width_next  = word;
                        HP_DEPTH, HP_CHANNELS, HP_SAMPBITS: fmt_next = {fmt_reg[15:0], s_tdata};
                        HP_RATE:   rate_next   = word[15:0];
                        HP_STAB: begin
                            if (word != TAG_STAB) begin
                                fail_item.kind = K_BAD_STAB;
                                push.n         = 2'd1;
                                push.item0     = fail_item;
                                phase_next     = PH_IDLE;
                            end
                        end
                        HP_TIMING: timing_next = word;
                        HP_COUNT: begin
                            // stream description, then the table or an empty-table end
                            entries_next                  = word;
                            push.item0.kind               = K_DESC;
                            push.item0.codec_kind         = codec_code(codec_reg);
                            push.item0.word_a             = width_reg;
                            push.item0.word_b             = height_reg;
                            push.item0.word_c             = timing_reg;
                            push.item0.word_d             = word;
                            push.item0.bits_per_pixel     = fmt_reg[23:16];
                            push.item0.audio_channels     = fmt_reg[15:8];
                            push.item0.audio_sample_bits  = fmt_reg[7:0];
                            push.item0.audio_frequency    = rate_reg;
                            pos_next                      = 7'd0;
                            if (word == '0) begin
                                push.n     = 2'd2;
                                push.item1 = end_item;
                                phase_next = PH_IDLE;
                            end else begin
                                push.n                 = 2'd1;
                                push.item0.last_of_run = 1'b1;
                                phase_next             = PH_TABLE;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_TABLE: begin
                    pos_next = {3'd0, 4'(tpos + 4'd1)};
                    unique case (tpos)
                        TP_OFFSET: ew0_next = word + hdr_len_reg;
                        TP_LENGTH: ew1_next = word;
                        TP_INFO0:  ew2_next = word;
                        TP_INFO1: begin
                            push.item0.kind   = K_ENTRY;
                            push.item0.word_a = ew0_reg;
                            push.item0.word_b = ew1_reg;
                            push.item0.word_c = ew2_reg;
                            push.item0.word_d = word;
                            vf_next           = vf_end;
                            entries_next      = entries_dec;
                            if (entries_dec == '0) begin
                                push.n     = 2'd2;
                                push.item1 = end_item;
                                phase_next = PH_IDLE;
                            end else begin
                                push.n                 = 2'd1;
                                push.item0.last_of_run = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            ws_reg      <= '0;
            vf_reg      <= '0;
            entries_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            ws_reg      <= ws_next;
            vf_reg      <= vf_next;
            entries_reg <= entries_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_len_reg <= hdr_len_next;
        codec_reg   <= codec_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
        fmt_reg     <= fmt_next;
        rate_reg    <= rate_next;
        timing_reg  <= timing_next;
        ew0_reg     <= ew0_next;
        ew1_reg     <= ew1_next;
        ew2_reg     <= ew2_next;
    end

    // result queue parts the two sides
    fchp_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .status  (status)
    );

    assign pop      = m_tvalid && m_tready;
    assign s_tready = status.room2;
    assign m_tvalid = status.valid;
    assign m_tuser  = {head.codec_kind, head.kind};
    assign m_tlast  = head.last_of_run;
    assign m_tdata  = {head.audio_frequency, head.audio_sample_bits, head.audio_channels,
                       head.bits_per_pixel, head.word_d, head.word_c, head.word_b,
                       head.word_a};

    a_hdr_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (pos_reg <= HP_COUNT))
        else $error("header position past sample count");

    a_tbl_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TABLE) |-> (pos_reg[6:4] == 3'd0))
        else $error("table position outside one entry");

    a_pair_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (push.item1.kind == K_END || push.item1.kind == K_UNKNOWN_CODEC))
        else $error("second item of a byte is not a table end");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !start && phase_reg == PH_IDLE) |=> (phase_reg == PH_IDLE && !$past(push.n != 2'd0)))
        else $error("idle parser produced results");

endmodule
